[design/assert_macros.svh]
// assertion macros shared by the polyline self-intersection test rtl
// expects clock and reset signals in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[design/psi_pkg.sv]
// shared types, micro-op table and constants for the polyline self-intersection test
// no dependencies
package psi_pkg;

   typedef enum logic [4:0] {
      OP_U0, OP_U1, OP_U2, OP_V0, OP_V1, OP_V2, OP_W0, OP_W1, OP_W2,
      OP_A, OP_B, OP_C, OP_D, OP_E, OP_S, OP_T, OP_F0, OP_F1, OP_F2
   } op_src_type;

   typedef enum logic [2:0] {
      ACC_KEEP, ACC_ZERO, ACC_W0, ACC_W1, ACC_W2
   } acc_init_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_A, DST_B, DST_C, DST_D, DST_E, DST_DET, DST_NS, DST_NT,
      DST_F0, DST_F1, DST_F2
   } dst_type;

   typedef struct packed {
      op_src_type   src_a;
      op_src_type   src_b;
      logic         neg;
      acc_init_type init;
      dst_type      dst;
   } uop_type;

   typedef struct packed {
      logic done;
      logic close;
   } pair_sts_type;

   localparam logic [4:0] STEP_PRE_SEL = 5'd20;
   localparam logic [4:0] STEP_POST    = 5'd21;
   localparam logic [4:0] STEP_LAST    = 5'd29;

   function automatic uop_type mk_uop(input op_src_type sa, input op_src_type sb,
                                      input logic ng, input acc_init_type ini,
                                      input dst_type ds);
      uop_type r;
      r.src_a = sa;
      r.src_b = sb;
      r.neg   = ng;
      r.init  = ini;
      r.dst   = ds;
      return r;
   endfunction

   function automatic uop_type psi_uop(input logic [4:0] step);
      uop_type r;
      case (step)
         5'd0:  r = mk_uop(OP_U0, OP_U0, 1'b0, ACC_ZERO, DST_NONE);
         5'd1:  r = mk_uop(OP_U1, OP_U1, 1'b0, ACC_KEEP, DST_NONE);
         5'd2:  r = mk_uop(OP_U2, OP_U2, 1'b0, ACC_KEEP, DST_A);
         5'd3:  r = mk_uop(OP_U0, OP_V0, 1'b0, ACC_ZERO, DST_NONE);
         5'd4:  r = mk_uop(OP_U1, OP_V1, 1'b0, ACC_KEEP, DST_NONE);
         5'd5:  r = mk_uop(OP_U2, OP_V2, 1'b0, ACC_KEEP, DST_B);
         5'd6:  r = mk_uop(OP_V0, OP_V0, 1'b0, ACC_ZERO, DST_NONE);
         5'd7:  r = mk_uop(OP_V1, OP_V1, 1'b0, ACC_KEEP, DST_NONE);
         5'd8:  r = mk_uop(OP_V2, OP_V2, 1'b0, ACC_KEEP, DST_C);
         5'd9:  r = mk_uop(OP_U0, OP_W0, 1'b0, ACC_ZERO, DST_NONE);
         5'd10: r = mk_uop(OP_U1, OP_W1, 1'b0, ACC_KEEP, DST_NONE);
         5'd11: r = mk_uop(OP_U2, OP_W2, 1'b0, ACC_KEEP, DST_D);
         5'd12: r = mk_uop(OP_V0, OP_W0, 1'b0, ACC_ZERO, DST_NONE);
         5'd13: r = mk_uop(OP_V1, OP_W1, 1'b0, ACC_KEEP, DST_NONE);
         5'd14: r = mk_uop(OP_V2, OP_W2, 1'b0, ACC_KEEP, DST_E);
         5'd15: r = mk_uop(OP_A,  OP_C,  1'b0, ACC_ZERO, DST_NONE);
         5'd16: r = mk_uop(OP_B,  OP_B,  1'b1, ACC_KEEP, DST_DET);
         5'd17: r = mk_uop(OP_B,  OP_E,  1'b0, ACC_ZERO, DST_NONE);
         5'd18: r = mk_uop(OP_C,  OP_D,  1'b1, ACC_KEEP, DST_NS);
         5'd19: r = mk_uop(OP_A,  OP_E,  1'b0, ACC_ZERO, DST_NONE);
         5'd20: r = mk_uop(OP_B,  OP_D,  1'b1, ACC_KEEP, DST_NT);
         5'd21: r = mk_uop(OP_S,  OP_U0, 1'b0, ACC_W0,   DST_NONE);
         5'd22: r = mk_uop(OP_T,  OP_V0, 1'b1, ACC_KEEP, DST_F0);
         5'd23: r = mk_uop(OP_S,  OP_U1, 1'b0, ACC_W1,   DST_NONE);
         5'd24: r = mk_uop(OP_T,  OP_V1, 1'b1, ACC_KEEP, DST_F1);
         5'd25: r = mk_uop(OP_S,  OP_U2, 1'b0, ACC_W2,   DST_NONE);
         5'd26: r = mk_uop(OP_T,  OP_V2, 1'b1, ACC_KEEP, DST_F2);
         5'd27: r = mk_uop(OP_F0, OP_F0, 1'b0, ACC_ZERO, DST_NONE);
         5'd28: r = mk_uop(OP_F1, OP_F1, 1'b0, ACC_KEEP, DST_NONE);
         5'd29: r = mk_uop(OP_F2, OP_F2, 1'b0, ACC_KEEP, DST_NONE);
         default: r = mk_uop(OP_U0, OP_U0, 1'b0, ACC_KEEP, DST_NONE);
      endcase
      return r;
   endfunction

endpackage

[design/psi_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module psi_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/psi_div.sv]
// iterative restoring divider giving num/den clamped to [0, one] in fixed point
// no dependencies; one quotient bit per cycle
module psi_div #(
   parameter int ACC_W     = 52,
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] num,
   input  logic signed [ACC_W-1:0] den,
   output logic                    done,
   output logic [FRAC_BITS:0]      quot
);

   localparam int CW = $clog2(FRAC_BITS + 1);
   localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [ACC_W:0]   rem_ff, rem_in;
   logic [ACC_W-1:0] den_ff, den_in;
   logic [FRAC_BITS:0] q_ff, q_in;

   logic [ACC_W-1:0] un, ud;
   logic [ACC_W:0]   rem2;
   logic             ge;

   always_comb begin
      un   = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
      ud   = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
      rem2 = {rem_ff[ACC_W-1:0], 1'b0};
      ge   = rem2 >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         if (num == '0 || (num[ACC_W-1] != den[ACC_W-1])) begin
            q_in    = '0;
            done_in = 1'b1;
         end else if (un >= ud) begin
            q_in    = ONE_Q;
            done_in = 1'b1;
         end else begin
            rem_in  = {1'b0, un};
            den_in  = ud;
            q_in    = '0;
            cnt_in  = CW'(FRAC_BITS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? rem2 - {1'b0, den_ff} : rem2;
         q_in   = {q_ff[FRAC_BITS-1:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

[design/psi_pair.sv]
// segment pair evaluator: shared multiplier and accumulator run by a micro-op table
// depends on psi_pkg, psi_div and assert_macros.svh
`include "assert_macros.svh"
module psi_pair
   import psi_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [30:0]  eps,
   input  logic [95:0]  p0,
   input  logic [95:0]  p1,
   input  logic [95:0]  q0,
   input  logic [95:0]  q1,
   output pair_sts_type sts
);

   localparam int ACC_W = 68 - FRAC_BITS;
   localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(64'sh7fff_ffff);
   localparam logic signed [ACC_W-1:0] S32_MIN = ACC_W'(-64'sh8000_0000);
   localparam logic signed [ACC_W-1:0] F_MAX   = ACC_W'(64'sh ffff_ffff);
   localparam logic signed [ACC_W-1:0] F_MIN   = ACC_W'(-64'sh ffff_ffff);
   localparam logic signed [32:0]      F33_MAX = {1'b0, {32{1'b1}}};
   localparam logic signed [32:0]      ONE_Q   = 33'(64'sd1 << FRAC_BITS);

   typedef enum logic [7:0] {
      P_IDLE = 8'b0000_0001,
      P_UVW  = 8'b0000_0010,
      P_MUL  = 8'b0000_0100,
      P_ACC  = 8'b0000_1000,
      P_SEL  = 8'b0001_0000,
      P_DIVS = 8'b0010_0000,
      P_DIVT = 8'b0100_0000,
      P_CMP  = 8'b1000_0000
   } pstate_type;

   pstate_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       done_ff, done_in;
   logic       close_ff, close_in;

   logic signed [32:0] u_ff [3], u_in [3];
   logic signed [32:0] v_ff [3], v_in [3];
   logic signed [32:0] w_ff [3], w_in [3];
   logic signed [32:0] f_ff [3], f_in [3];
   logic signed [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in, e_ff, e_in;
   logic signed [ACC_W-1:0] det_ff, det_in, ns_ff, ns_in, nt_ff, nt_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [32:0] s_ff, s_in, t_ff, t_in;
   logic signed [65:0] prod_ff, prod_in;

   uop_type uop;
   logic signed [ACC_W-1:0] sh, base, acc_sum, eps_acc;
   logic signed [31:0]      sat_v;
   logic signed [32:0]      clamp_v;

   logic [ACC_W-1:0]   abs_det;
   logic               big, a_small, c_small, flip;
   logic signed [31:0] e2, eps32;
   logic signed [32:0] eb, s_near, t_near, s_pre, t_pre;

   logic               div_start, div_done;
   logic [FRAC_BITS:0] div_quot;

   function automatic logic signed [32:0] sx33(input logic [31:0] x);
      return signed'({x[31], x});
   endfunction

   function automatic logic signed [32:0] pick(input op_src_type sel);
      logic signed [32:0] r;
      case (sel)
         OP_U0:   r = u_ff[0];
         OP_U1:   r = u_ff[1];
         OP_U2:   r = u_ff[2];
         OP_V0:   r = v_ff[0];
         OP_V1:   r = v_ff[1];
         OP_V2:   r = v_ff[2];
         OP_W0:   r = w_ff[0];
         OP_W1:   r = w_ff[1];
         OP_W2:   r = w_ff[2];
         OP_A:    r = 33'(a_ff);
         OP_B:    r = 33'(b_ff);
         OP_C:    r = 33'(c_ff);
         OP_D:    r = 33'(d_ff);
         OP_E:    r = 33'(e_ff);
         OP_S:    r = s_ff;
         OP_T:    r = t_ff;
         OP_F0:   r = f_ff[0];
         OP_F1:   r = f_ff[1];
         OP_F2:   r = f_ff[2];
         default: r = '0;
      endcase
      return r;
   endfunction

   psi_div #(.ACC_W(ACC_W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (state_ff == P_SEL ? ns_ff : nt_ff),
      .den   (det_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // accumulate path
   always_comb begin
      uop = psi_uop(step_ff);
      sh  = ACC_W'(prod_ff >>> FRAC_BITS);
      case (uop.init)
         ACC_ZERO: base = '0;
         ACC_W0:   base = ACC_W'(w_ff[0]);
         ACC_W1:   base = ACC_W'(w_ff[1]);
         ACC_W2:   base = ACC_W'(w_ff[2]);
         default:  base = acc_ff;
      endcase
      acc_sum = uop.neg ? base - sh : base + sh;
      if (acc_sum > S32_MAX) begin
         sat_v = 32'sh7fff_ffff;
      end else if (acc_sum < S32_MIN) begin
         sat_v = 32'sh8000_0000;
      end else begin
         sat_v = acc_sum[31:0];
      end
      if (acc_sum > F_MAX) begin
         clamp_v = F33_MAX;
      end else if (acc_sum < F_MIN) begin
         clamp_v = -F33_MAX;
      end else begin
         clamp_v = acc_sum[32:0];
      end
   end

   // near-parallel rule and branch choice
   always_comb begin
      abs_det = det_ff[ACC_W-1] ? ACC_W'(-det_ff) : ACC_W'(det_ff);
      big     = abs_det > {{(ACC_W-31){1'b0}}, eps};
      eps32   = signed'({1'b0, eps});
      eps_acc = signed'({{(ACC_W-31){1'b0}}, eps});
      a_small = a_ff < eps32;
      c_small = c_ff < eps32;
      flip    = a_ff > c_ff;
      e2      = flip ? d_ff : e_ff;
      eb      = sx33(e2) + sx33(b_ff);
      if (eb < 0) begin
         s_near = ONE_Q;
         t_near = '0;
      end else if (eb < ONE_Q) begin
         s_near = ONE_Q;
         t_near = eb;
      end else if (sx33(e2) < ONE_Q) begin
         s_near = '0;
         t_near = sx33(e2);
      end else begin
         s_near = '0;
         t_near = ONE_Q;
      end
      if (a_small && c_small) begin
         s_pre = '0;
         t_pre = '0;
      end else if (flip) begin
         s_pre = t_near;
         t_pre = s_near;
      end else begin
         s_pre = s_near;
         t_pre = t_near;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      close_in  = close_ff;
      div_start = 1'b0;
      u_in = u_ff;
      v_in = v_ff;
      w_in = w_ff;
      f_in = f_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      det_in  = det_ff;
      ns_in   = ns_ff;
      nt_in   = nt_ff;
      acc_in  = acc_ff;
      s_in    = s_ff;
      t_in    = t_ff;
      prod_in = prod_ff;
      unique case (state_ff)
         P_IDLE: begin
            if (start) begin
               state_in = P_UVW;
            end
         end
         P_UVW: begin
            for (int k = 0; k < 3; k++) begin
               u_in[k] = sx33(p1[32*k +: 32]) - sx33(p0[32*k +: 32]);
               v_in[k] = sx33(q1[32*k +: 32]) - sx33(q0[32*k +: 32]);
               w_in[k] = sx33(p0[32*k +: 32]) - sx33(q0[32*k +: 32]);
            end
            step_in  = '0;
            state_in = P_MUL;
         end
         P_MUL: begin
            prod_in  = pick(uop.src_a) * pick(uop.src_b);
            state_in = P_ACC;
         end
         P_ACC: begin
            acc_in = acc_sum;
            case (uop.dst)
               DST_A:   a_in    = sat_v;
               DST_B:   b_in    = sat_v;
               DST_C:   c_in    = sat_v;
               DST_D:   d_in    = sat_v;
               DST_E:   e_in    = sat_v;
               DST_DET: det_in  = acc_sum;
               DST_NS:  ns_in   = acc_sum;
               DST_NT:  nt_in   = acc_sum;
               DST_F0:  f_in[0] = clamp_v;
               DST_F1:  f_in[1] = clamp_v;
               DST_F2:  f_in[2] = clamp_v;
               default: ;
            endcase
            if (step_ff == STEP_PRE_SEL) begin
               state_in = P_SEL;
            end else if (step_ff == STEP_LAST) begin
               state_in = P_CMP;
            end else begin
               step_in  = step_ff + 5'd1;
               state_in = P_MUL;
            end
         end
         P_SEL: begin
            if (big) begin
               div_start = 1'b1;
               state_in  = P_DIVS;
            end else begin
               s_in     = s_pre;
               t_in     = t_pre;
               step_in  = STEP_POST;
               state_in = P_MUL;
            end
         end
         P_DIVS: begin
            if (div_done) begin
               s_in      = 33'(div_quot);
               div_start = 1'b1;
               state_in  = P_DIVT;
            end
         end
         P_DIVT: begin
            if (div_done) begin
               t_in     = 33'(div_quot);
               step_in  = STEP_POST;
               state_in = P_MUL;
            end
         end
         P_CMP: begin
            close_in = acc_ff < eps_acc;
            done_in  = 1'b1;
            state_in = P_IDLE;
         end
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         done_ff  <= 1'b0;
         close_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         close_ff <= close_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      w_ff    <= w_in;
      f_ff    <= f_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      e_ff    <= e_in;
      det_ff  <= det_in;
      ns_ff   <= ns_in;
      nt_ff   <= nt_in;
      acc_ff  <= acc_in;
      s_ff    <= s_in;
      t_ff    <= t_in;
      prod_ff <= prod_in;
   end

   assign sts.done  = done_ff;
   assign sts.close = close_ff;

   `ASSERT_IMP(a_start_idle, start, state_ff == P_IDLE, "pair start while busy")
   `ASSERT_IMP(a_div_ctx, div_done, state_ff == P_DIVS || state_ff == P_DIVT, "stray divide done")
   `ASSERT_NXT(a_cmp_done, state_ff == P_CMP, sts.done, "compare without done")

endmodule

[design/polyline_self_intersection_test.sv]
// top level of the polyline self-intersection test: vertex store, pair scan and result word
// depends on psi_pkg, psi_ram, psi_pair and assert_macros.svh
//
// Vertices are taken one word per cycle and written to the vertex ram; beyond
// MAX_VERTS they are dropped and the overflow flag is set. The word marked tlast starts a scan
// over all non-adjacent segment pairs, during which no input is taken. Each pair takes four ram
// reads and 30 multiply-accumulate steps through a shared 33x33 multiplier, and the two
// bit-serial ratio divisions when the closest points need them. An n-vertex line has
// (n-2)(n-3)/2 pairs; the scan stops at the first pair found within tolerance. One result
// word follows.
`include "assert_macros.svh"
module polyline_self_intersection_test
   import psi_pkg::*;
#(
   parameter int MAX_VERTS = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // coord_x, coord_y, coord_z
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // intersects, overflowed, zero fill
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [30:0] csr_wr_data
);

   localparam int ADDR_W = $clog2(MAX_VERTS);
   localparam int CNT_W  = $clog2(MAX_VERTS + 1);
   localparam logic CSR_CLOSED = 1'b0;
   localparam logic CSR_EPS    = 1'b1;

   typedef enum logic [5:0] {
      ST_LOAD  = 6'b00_0001,
      ST_NEXT  = 6'b00_0010,
      ST_RADDR = 6'b00_0100,
      ST_RDATA = 6'b00_1000,
      ST_EVAL  = 6'b01_0000,
      ST_DONE  = 6'b10_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in;
   logic             ovf_ff, ovf_in, hit_ff, hit_in;
   logic [1:0]       rd_idx_ff, rd_idx_in;
   logic             closed_ff, closed_in;
   logic [30:0]      eps_ff, eps_in;
   logic             rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in, rsp_ovf_ff, rsp_ovf_in;
   logic [95:0]      vtx_ff [4];

   logic              req_acc, full, rsp_load, pair_start;
   logic [CNT_W:0]    n_ext, j_p2, i_p5;
   logic [CNT_W-1:0]  rd_sel;
   logic [95:0]       ram_rdata;
   pair_sts_type      pair_sts;

   assign req_tready = state_ff == ST_LOAD;
   assign req_acc    = req_tvalid && req_tready;
   assign full       = cnt_ff == CNT_W'(MAX_VERTS);
   assign n_ext      = {1'b0, cnt_ff};
   assign j_p2       = {1'b0, j_ff} + (CNT_W+1)'(2);
   assign i_p5       = {1'b0, i_ff} + (CNT_W+1)'(5);
   assign rsp_load   = state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready);
   assign pair_start = state_ff == ST_RDATA && rd_idx_ff == 2'd3;

   always_comb begin
      case (rd_idx_ff)
         2'd0:    rd_sel = i_ff;
         2'd1:    rd_sel = i_ff + CNT_W'(1);
         2'd2:    rd_sel = j_ff;
         default: rd_sel = j_ff + CNT_W'(1);
      endcase
   end

   psi_ram #(.WIDTH(96), .DEPTH(MAX_VERTS)) u_vram (
      .clock   (clock),
      .wr_en   (req_acc && !full),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rd_sel[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   psi_pair #(.FRAC_BITS(FRAC_BITS)) u_pair (
      .clock (clock),
      .reset (reset),
      .start (pair_start),
      .eps   (eps_ff),
      .p0    (vtx_ff[0]),
      .p1    (vtx_ff[1]),
      .q0    (vtx_ff[2]),
      .q1    (vtx_ff[3]),
      .sts   (pair_sts)
   );

   always_comb begin
      closed_in = closed_ff;
      eps_in    = eps_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CLOSED: closed_in = csr_wr_data[0];
            CSR_EPS:    eps_in    = csr_wr_data;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      hit_in       = hit_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  i_in     = '0;
                  j_in     = CNT_W'(2);
                  hit_in   = 1'b0;
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            if (j_p2 > n_ext) begin
               if (i_p5 > n_ext) begin
                  state_in = ST_DONE;
               end else begin
                  i_in = i_ff + CNT_W'(1);
                  j_in = i_ff + CNT_W'(3);
               end
            end else if (closed_ff && i_ff == '0 && j_p2 == n_ext) begin
               j_in = j_ff + CNT_W'(1);
            end else begin
               rd_idx_in = '0;
               state_in  = ST_RADDR;
            end
         end
         ST_RADDR: state_in = ST_RDATA;
         ST_RDATA: begin
            rd_idx_in = rd_idx_ff + 2'd1;
            state_in  = (rd_idx_ff == 2'd3) ? ST_EVAL : ST_RADDR;
         end
         ST_EVAL: begin
            if (pair_sts.done) begin
               if (pair_sts.close) begin
                  hit_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_NEXT;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_ovf_in   = ovf_ff;
               cnt_in       = '0;
               ovf_in       = 1'b0;
               hit_in       = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         rd_idx_ff    <= '0;
         closed_ff    <= 1'b0;
         eps_ff       <= 31'd66;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         hit_ff       <= hit_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rd_idx_ff    <= rd_idx_in;
         closed_ff    <= closed_in;
         eps_ff       <= eps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
      rsp_ovf_ff <= rsp_ovf_in;
      if (state_ff == ST_RDATA) begin
         vtx_ff[rd_idx_ff] <= ram_rdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ovf_ff, rsp_hit_ff};

   `ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(MAX_VERTS), "vertex count past store size")
   `ASSERT_IMP(a_pair_range, pair_start, j_p2 <= n_ext && j_ff >= i_ff + CNT_W'(2), "bad pair")
   `ASSERT_NXT(a_clear_after_rsp, rsp_load, cnt_ff == '0 && !ovf_ff, "line state not cleared")

endmodule

[tb/polyline_self_intersection_test_test.sv]
// testbench for polyline_self_intersection_test: streams 3d polylines, predicts each result word
// with a fixed-point segment distance model and checks it; depends on psi_pkg and the rtl only
module polyline_self_intersection_test_test;
   import psi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     MAXV = 256;
   localparam int     FRAC = 16;
   localparam longint ONE  = longint'(1) << FRAC;
   localparam longint MAG  = 64'h0000_0000_FFFF_FFFF;
   localparam bit     REG_CLOSED = 1'b0;
   localparam bit     REG_EPS    = 1'b1;
   localparam int     STALL_LIMIT = 100000;

   typedef struct packed {
      logic intersects;
      logic overflowed;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;   // coord_x, coord_y, coord_z
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // intersects, overflowed, zero fill
   logic        csr_wr_en;
   logic        csr_index;
   logic [30:0] csr_wr_data;

   polyline_self_intersection_test i_dut (.*);

   longint      pts[MAXV][3];
   int          vert_count;
   bit          drop_seen;
   bit          closed_cfg;
   longint      eps_cfg;
   verdict_type verdicts_due[$];
   int          errors;
   int          sent;
   bit          jitter_on;
   int          hold_cycles;
   int          quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint sat32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint mul_q(input longint x, input longint y);
      bit neg;
      longint unsigned ux, uy, m;
      neg = (x < 0) != (y < 0);
      ux = (x < 0) ? longint'(-x) : x;
      uy = (y < 0) ? longint'(-y) : y;
      m = ux * uy;
      if (!neg) return longint'(m >> FRAC);
      return -longint'((m + longint'(ONE - 1)) >> FRAC);
   endfunction

   function automatic longint dot3(input longint p[3], input longint q[3]);
      return sat32(mul_q(p[0], q[0]) + mul_q(p[1], q[1]) + mul_q(p[2], q[2]));
   endfunction

   function automatic longint clamp_ratio(input longint num, input longint den);
      longint unsigned un, ud;
      if (num == 0 || ((num < 0) != (den < 0))) return 0;
      un = (num < 0) ? longint'(-num) : num;
      ud = (den < 0) ? longint'(-den) : den;
      if (un >= ud) return ONE;
      return longint'((un << FRAC) / ud);
   endfunction

   function automatic bit segments_close(input int i, input int j);
      longint u[3], v[3], w[3];
      longint a, b, c, d, e, det, adet, s, t, eb, df, sum, tmp;
      bit flip;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         u[k] = pts[i+1][k] - pts[i][k];
         v[k] = pts[j+1][k] - pts[j][k];
         w[k] = pts[i][k] - pts[j][k];
      end
      a = dot3(u, u);
      b = dot3(u, v);
      c = dot3(v, v);
      d = dot3(u, w);
      e = dot3(v, w);
      det = mul_q(a, c) - mul_q(b, b);
      adet = (det < 0) ? -det : det;
      if (adet > eps_cfg) begin
         s = clamp_ratio(mul_q(b, e) - mul_q(c, d), det);
         t = clamp_ratio(mul_q(a, e) - mul_q(b, d), det);
      end else if (a < eps_cfg && c < eps_cfg) begin
         s = 0;
         t = 0;
      end else begin
         flip = a > c;
         if (flip) e = d;
         eb = e + b;
         if (eb < 0) begin
            s = ONE; t = 0;
         end else if (eb < ONE) begin
            s = ONE; t = eb;
         end else if (e < ONE) begin
            s = 0; t = e;
         end else begin
            s = 0; t = ONE;
         end
         if (flip) begin
            tmp = s; s = t; t = tmp;
         end
      end
      for (int k = 0; k < 3; k++) begin
         df = w[k] + mul_q(s, u[k]) - mul_q(t, v[k]);
         if (df > MAG) df = MAG;
         if (df < -MAG) df = -MAG;
         sum += mul_q(df, df);
      end
      return sum < eps_cfg;
   endfunction

   function automatic bit polyline_hits();
      for (int i = 0; i < vert_count - 1; i++)
         for (int j = i + 2; j < vert_count - 1; j++) begin
            if (closed_cfg && i == 0 && j == vert_count - 2) continue;
            if (segments_close(i, j)) return 1'b1;
         end
      return 1'b0;
   endfunction

   function automatic void take_vertex(input logic [31:0] x, y, z, input bit last);
      verdict_type r;
      if (vert_count < MAXV) begin
         pts[vert_count][0] = longint'($signed(x));
         pts[vert_count][1] = longint'($signed(y));
         pts[vert_count][2] = longint'($signed(z));
         vert_count++;
      end else begin
         drop_seen = 1'b1;
      end
      if (last) begin
         r.intersects = polyline_hits();
         r.overflowed = drop_seen;
         verdicts_due.push_back(r);
         vert_count = 0;
         drop_seen = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      verdict_type exp_r;
      if (rsp_tvalid && rsp_tready) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected word %h", $time, rsp_tdata);
            errors++;
         end else begin
            exp_r = verdicts_due.pop_front();
            if (rsp_tdata[0] !== exp_r.intersects) begin
               $display("%0t: intersects expected %0b actual %0b", $time,
                        exp_r.intersects, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[1] !== exp_r.overflowed) begin
               $display("%0t: overflowed expected %0b actual %0b", $time,
                        exp_r.overflowed, rsp_tdata[1]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= jitter_on ? ($urandom_range(99) >= 16) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("polyline_self_intersection_test_test: errors");
            $finish;
         end
      end
   end

   task automatic send_vertex(input logic [31:0] x, y, z, input bit last);
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      take_vertex(x, y, z, last);
      sent++;
      if (jitter_on && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input bit idx, input logic [30:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_CLOSED) closed_cfg = val[0];
      else eps_cfg = longint'(val);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord(input bit wide);
      if (wide) return $urandom;
      return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
   endfunction

   task automatic send_polyline(input int n, input bit wide);
      for (int k = 0; k < n; k++)
         send_vertex(pick_coord(wide), pick_coord(wide), pick_coord(wide), k == n - 1);
   endtask

   task automatic test_shapes();
      logic [31:0] o;
      o = 32'h0001_0000;
      send_vertex(0, 0, 0, 1'b1);
      send_vertex(0, 0, 0, 1'b0);
      send_vertex(o, 0, 0, 1'b0);
      send_vertex(o, o, 0, 1'b1);
      // crossing segments first and third
      send_vertex(0, 0, 0, 1'b0);
      send_vertex(2 * o, 0, 0, 1'b0);
      send_vertex(o, o, 0, 1'b0);
      send_vertex(o, -o, 0, 1'b1);
      // antiparallel segments, unequal lengths both ways
      send_vertex(0, 0, 0, 1'b0);
      send_vertex(4 * o, 0, 0, 1'b0);
      send_vertex(4 * o, o, 0, 1'b0);
      send_vertex(o, o, 0, 1'b1);
      send_vertex(0, 0, o, 1'b0);
      send_vertex(o, 0, o, 1'b0);
      send_vertex(o, 0, 0, 1'b0);
      send_vertex(-3 * o, 0, 0, 1'b1);
      // all-degenerate points
      for (int k = 0; k < 4; k++) send_vertex(o, o, o, k == 3);
      // coordinate extremes
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
      send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_vertex(32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff, 1'b0);
      send_vertex(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 1'b0);
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
      drain();
   endtask

   task automatic test_settings();
      write_reg(REG_CLOSED, 31'd1);
      send_polyline(4, 1'b0);
      send_polyline(6, 1'b0);
      drain();
      write_reg(REG_EPS, 31'd0);
      send_polyline(5, 1'b0);
      for (int k = 0; k < 4; k++) send_vertex(0, 0, 0, k == 3);
      drain();
      write_reg(REG_EPS, 31'h7fff_ffff);
      write_reg(REG_CLOSED, 31'd0);
      send_polyline(5, 1'b1);
      send_polyline(4, 1'b0);
      drain();
      write_reg(REG_EPS, 31'd66);
   endtask

   task automatic test_overflow();
      for (int k = 0; k < MAXV + 4; k++)
         send_vertex(k < 4 ? 32'd0 : pick_coord(1'b1), k < 4 ? 32'd0 : pick_coord(1'b1),
                     k < 4 ? 32'd0 : pick_coord(1'b1), k == MAXV + 3);
      send_polyline(4, 1'b0);
      drain();
   endtask

   task automatic test_backpressure();
      hold_cycles = 400;
      for (int k = 0; k < 6; k++) send_polyline(4, 1'b0);
      drain();
   endtask

   task automatic test_random();
      int phase;
      phase = 0;
      while (sent < 1500) begin
         jitter_on = !(sent > 600 && sent < 900);
         send_polyline($urandom_range(1, 9), $urandom_range(99) < 30);
         if (sent > 400 * (phase + 1)) begin
            drain();
            phase++;
            write_reg(REG_CLOSED, 31'($urandom_range(1)));
            write_reg(REG_EPS, phase % 2 ? 31'($urandom_range(0, 1 << 20)) : 31'd66);
         end
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = 1'b0;
      csr_wr_data = '0;
      vert_count = 0;
      drop_seen = 1'b0;
      closed_cfg = 1'b0;
      eps_cfg = 66;
      errors = 0;
      sent = 0;
      jitter_on = 1'b1;
      hold_cycles = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_shapes();
      test_settings();
      test_overflow();
      test_backpressure();
      test_random();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("polyline_self_intersection_test_test: clean");
      end else begin
         $display("polyline_self_intersection_test_test: errors");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/psi_pkg.sv
design/psi_ram.sv
design/psi_div.sv
design/psi_pair.sv
design/polyline_self_intersection_test.sv
tb/polyline_self_intersection_test_test.sv
